// File: hw/rtl/nqp_pkg.sv
// Package for the NVMe queue pair engine: field widths, request kinds,
// outcome codes and the queue entry type. Used by every module of the block.
`timescale 1ns / 1ps

package nqp_pkg;

  localparam int DwordW     = 32;
  localparam int CqeW       = 16;
  localparam int StatusW    = 15;
  localparam int CidW       = 16;
  localparam int PtrW       = 6;
  localparam int DepthW     = 7;
  localparam int LimitW     = 23;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 23;
  localparam int InTdataW   = 48;
  localparam int OutTdataW  = 88;
  localparam int OutcomeW   = 3;

  localparam logic [DepthW-1:0] DepthReset = 7'd64;
  localparam logic [LimitW-1:0] LimitReset = 23'd5000000;

  localparam logic [CfgIdxW-1:0] CfgQueueDepth = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPollLimit  = 1'b1;

  typedef enum logic {
    REQ_SUBMIT = 1'b0,
    REQ_POLL   = 1'b1
  } req_kind_e;

  typedef enum logic [OutcomeW-1:0] {
    OC_SUBMITTED = 3'd0,
    OC_DONE_OK   = 3'd1,
    OC_DONE_ERR  = 3'd2,
    OC_WAITING   = 3'd3,
    OC_TIMEOUT   = 3'd4,
    OC_REJECTED  = 3'd5
  } outcome_e;

  typedef struct packed {
    req_kind_e           kind;
    logic                phase;
    logic [StatusW-1:0]  status_code;
    logic [DwordW-1:0]   dword0;
    logic [CqeW-1:0]     cqe;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// File: hw/rtl/nqp_front.sv
// Front part of the NVMe queue pair engine: accepts input items and
// classifies them into queue entries. Depends on nqp_pkg.
`timescale 1ns / 1ps

module nqp_front (
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [nqp_pkg::InTdataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  nqp_pkg::q_status_t            q_status_i,
  output logic                          push_o,
  output nqp_pkg::entry_t               entry_o
);

  logic [nqp_pkg::DwordW-1:0] dword0;
  logic [nqp_pkg::CqeW-1:0]   cqe;

  assign dword0 = s_axis_tdata[31:0];
  assign cqe    = s_axis_tdata[47:32];

  assign s_axis_tready = !q_status_i.full;
  assign push_o        = s_axis_tvalid && !q_status_i.full;

  always_comb begin
    entry_o.kind        = s_axis_tuser ? nqp_pkg::REQ_POLL : nqp_pkg::REQ_SUBMIT;
    entry_o.phase       = cqe[0];
    entry_o.status_code = cqe[15:1];
    entry_o.dword0      = dword0;
    entry_o.cqe         = cqe;
  end

endmodule

// File: hw/rtl/nqp_queue.sv
// Two-entry queue between the front and back parts of the NVMe queue pair
// engine. Depends on nqp_pkg.
`timescale 1ns / 1ps

module nqp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  nqp_pkg::entry_t    entry_i,
  input  logic               pop_i,
  output nqp_pkg::q_status_t q_status_o,
  output nqp_pkg::entry_t    head_o
);

  nqp_pkg::entry_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    q_status_o.valid = (cnt_q != 2'd0);
    q_status_o.full  = (cnt_q == 2'd2);
  end

  assign head_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: hw/rtl/nqp_back.sv
// Back part of the NVMe queue pair engine: configuration registers, queue
// pair state, execution of each entry and the output register. Depends on nqp_pkg.
`timescale 1ns / 1ps

module nqp_back #(
  parameter int MAX_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nqp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [nqp_pkg::CfgDataW-1:0]    cfg_data_i,
  input  nqp_pkg::q_status_t              q_status_i,
  input  nqp_pkg::entry_t                 head_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [nqp_pkg::OutTdataW-1:0]   m_axis_tdata,
  output logic [nqp_pkg::OutcomeW-1:0]    m_axis_tuser
);

  localparam int CapRaw = (MAX_DEPTH < 64) ? MAX_DEPTH : 64;
  localparam int Cap    = (CapRaw < 2) ? 2 : CapRaw;
  localparam logic [nqp_pkg::DepthW-1:0] DepthCap = nqp_pkg::DepthW'(Cap);
  localparam logic [nqp_pkg::DepthW-1:0] DepthMin = 7'd2;

  logic [nqp_pkg::DepthW-1:0] queue_depth_q;
  logic [nqp_pkg::LimitW-1:0] poll_limit_q;

  logic [nqp_pkg::CidW-1:0]   cid_q, cid_d;
  logic [nqp_pkg::PtrW-1:0]   tail_q, tail_d;
  logic [nqp_pkg::PtrW-1:0]   head_q, head_d;
  logic                       phase_q, phase_d;
  logic                       outst_q, outst_d;
  logic [nqp_pkg::LimitW-1:0] stale_q, stale_d;

  logic                       out_valid_q, out_valid_d;
  logic [nqp_pkg::OutTdataW-1:0] out_data_q, out_data_d;
  nqp_pkg::outcome_e          out_oc_q, out_oc_d;

  logic [nqp_pkg::DepthW-1:0] depth_eff;
  logic [nqp_pkg::LimitW-1:0] limit_eff;
  logic [nqp_pkg::LimitW-1:0] stale_inc;
  logic [nqp_pkg::PtrW-1:0]   tail_adv;
  logic [nqp_pkg::PtrW-1:0]   head_adv;
  logic                       take;

  function automatic logic [nqp_pkg::PtrW-1:0] advance(
    input logic [nqp_pkg::PtrW-1:0]   ptr,
    input logic [nqp_pkg::DepthW-1:0] depth
  );
    logic [nqp_pkg::DepthW-1:0] n;
    n = {1'b0, ptr} + 7'd1;
    if (n >= depth) begin
      n = '0;
    end
    return n[nqp_pkg::PtrW-1:0];
  endfunction

  always_comb begin
    if (queue_depth_q < DepthMin) begin
      depth_eff = DepthMin;
    end else if (queue_depth_q > DepthCap) begin
      depth_eff = DepthCap;
    end else begin
      depth_eff = queue_depth_q;
    end
    limit_eff = (poll_limit_q == '0) ? 23'd1 : poll_limit_q;
    stale_inc = stale_q + 23'd1;
    tail_adv  = advance(tail_q, depth_eff);
    head_adv  = advance(head_q, depth_eff);
    take      = q_status_i.valid && (!out_valid_q || m_axis_tready);
  end

  assign pop_o = take;

  always_comb begin
    cid_d       = cid_q;
    tail_d      = tail_q;
    head_d      = head_q;
    phase_d     = phase_q;
    outst_d     = outst_q;
    stale_d     = stale_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_oc_d    = out_oc_q;
    if (take) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      out_oc_d    = nqp_pkg::OC_REJECTED;
      unique case (head_i.kind)
        nqp_pkg::REQ_SUBMIT: begin
          if (!outst_q) begin
            out_oc_d          = nqp_pkg::OC_SUBMITTED;
            out_data_d[31:0]  = {cid_q, head_i.dword0[15:0]};
            out_data_d[37:32] = tail_q;
            out_data_d[43:38] = tail_adv;
            cid_d             = cid_q + 16'd1;
            tail_d            = tail_adv;
            outst_d           = 1'b1;
            stale_d           = '0;
          end
        end
        nqp_pkg::REQ_POLL: begin
          if (outst_q) begin
            if (head_i.phase == phase_q) begin
              out_oc_d = (head_i.status_code != '0) ? nqp_pkg::OC_DONE_ERR
                                                     : nqp_pkg::OC_DONE_OK;
              out_data_d[49:44] = head_adv;
              out_data_d[64:50] = head_i.status_code;
              out_data_d[80:65] = head_i.cqe;
              head_d            = head_adv;
              phase_d           = (head_adv == '0) ? !phase_q : phase_q;
              outst_d           = 1'b0;
              stale_d           = '0;
            end else if (stale_inc >= limit_eff) begin
              out_oc_d = nqp_pkg::OC_TIMEOUT;
              outst_d  = 1'b0;
              stale_d  = '0;
            end else begin
              out_oc_d = nqp_pkg::OC_WAITING;
              stale_d  = stale_inc;
            end
          end
        end
        default: begin
          out_oc_d = nqp_pkg::OC_REJECTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_depth_q <= nqp_pkg::DepthReset;
      poll_limit_q  <= nqp_pkg::LimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nqp_pkg::CfgQueueDepth: queue_depth_q <= cfg_data_i[nqp_pkg::DepthW-1:0];
        nqp_pkg::CfgPollLimit:  poll_limit_q  <= cfg_data_i[nqp_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cid_q       <= '0;
      tail_q      <= '0;
      head_q      <= '0;
      phase_q     <= 1'b1;
      outst_q     <= 1'b0;
      stale_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cid_q       <= cid_d;
      tail_q      <= tail_d;
      head_q      <= head_d;
      phase_q     <= phase_d;
      outst_q     <= outst_d;
      stale_q     <= stale_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_oc_q   <= out_oc_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_oc_q;

endmodule

// File: hw/rtl/nvme_queue_pair_engine.sv
// Top level of the NVMe queue pair engine: front, queue and back parts.
// Depends on nqp_pkg, nqp_front, nqp_queue and nqp_back.
//
// The slave stream carries requests: tuser is the request kind (submit or
// poll) and tdata holds command dword 0 and the completion status half-word.
// The master stream returns exactly one result item per request: tuser is
// the outcome code and tdata holds the stamped dword 0, the submission slot,
// both doorbell values, the status code and the consumed status half-word.
// The configuration port writes the queue depth and the stale poll limit;
// the user must write it only while the block is idle, and the block
// itself does not enforce this. An accepted item is written into the
// queue and, once at its head, executed into the output register, and
// one item is taken every cycle while the receiver does not stall. The
// rate is set by the back part, which executes one queue entry per cycle,
// unless stalled, against the pointer, phase and timeout state.
// Reset clears the queue and output register and returns the queue pair to
// its start state (tail and head zero, expected phase one, nothing
// outstanding). When the receiver stalls, the result holds in the output
// register, the two-entry queue fills, and then tready drops.
`timescale 1ns / 1ps

module nvme_queue_pair_engine #(
  parameter int MAX_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nqp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [nqp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: cmd_dword0[31:0], cqe_status[47:32].
  input  logic [nqp_pkg::InTdataW-1:0]   s_axis_tdata,
  // Fields from bit 0: req_type[0].
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0: cmd_dword0_out[31:0], sq_slot[37:32],
  // sq_doorbell_value[43:38], cq_doorbell_value[49:44], status_code[64:50],
  // completion_status[80:65], zero fill[87:81].
  output logic [nqp_pkg::OutTdataW-1:0]  m_axis_tdata,
  // Fields from bit 0: outcome[2:0].
  output logic [nqp_pkg::OutcomeW-1:0]   m_axis_tuser
);

  nqp_pkg::q_status_t q_status;
  nqp_pkg::entry_t    push_entry;
  nqp_pkg::entry_t    head_entry;
  logic               push;
  logic               pop;

  nqp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_status_i    (q_status),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  nqp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .entry_i    (push_entry),
    .pop_i      (pop),
    .q_status_o (q_status),
    .head_o     (head_entry)
  );

  nqp_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .q_status_i    (q_status),
    .head_i        (head_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: hw/rtl/nqp_checker.sv
// Port-level checker for the NVMe queue pair engine, bound to the top level.
// Depends on nqp_pkg.
`timescale 1ns / 1ps

module nqp_port_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [nqp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input logic [nqp_pkg::CfgDataW-1:0]   cfg_data_i,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [nqp_pkg::InTdataW-1:0]   s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [nqp_pkg::OutTdataW-1:0]  m_axis_tdata,
  input logic [nqp_pkg::OutcomeW-1:0]   m_axis_tuser
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("Result item shown during reset.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result item changed or vanished.");

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= nqp_pkg::OC_REJECTED)
    else $error("Undefined outcome code.");

  a_doorbell_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == nqp_pkg::OC_SUBMITTED
      |-> m_axis_tdata[43:38] != m_axis_tdata[37:32])
    else $error("Submission doorbell equals the slot just written.");

  a_submit_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != nqp_pkg::OC_SUBMITTED
      |-> m_axis_tdata[43:0] == '0)
    else $error("Submission fields set on a result that is not a submit.");

endmodule

bind nvme_queue_pair_engine nqp_port_checker u_nqp_port_checker (.*);

// File: bench/nqp_checker.sv
// Result checker for the NVMe queue pair engine: follows the register port and
// both streams, predicts each result and compares it field by field.
// Depends on nqp_pkg for widths, request kinds, outcome codes and register indexes.
`timescale 1ns / 1ps

module nqp_checker
  import nqp_pkg::*;
#(
  parameter int MAX_DEPTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [InTdataW-1:0]   s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OutTdataW-1:0]  m_axis_tdata,
  input  logic [OutcomeW-1:0]   m_axis_tuser,
  output int                    fail_o,
  output int                    pending_o,
  output int                    requests_o,
  output int                    results_o,
  output logic                  phase_o
);

  typedef struct {
    outcome_e            outcome;
    logic [DwordW-1:0]   dword0;
    logic [PtrW-1:0]     slot;
    logic [PtrW-1:0]     sq_db;
    logic [PtrW-1:0]     cq_db;
    logic [StatusW-1:0]  status;
    logic [CqeW-1:0]     cqe;
  } result_t;

  localparam int DepthCap = (MAX_DEPTH < 2) ? 2 : ((MAX_DEPTH > 64) ? 64 : MAX_DEPTH);

  logic [DepthW-1:0] depth_reg;
  logic [LimitW-1:0] limit_reg;
  logic [CidW-1:0]   cid_next;
  logic [PtrW-1:0]   sq_tail;
  logic [PtrW-1:0]   cq_head;
  logic              phase_exp;
  logic              busy;
  logic [LimitW-1:0] stale_cnt;
  result_t           due_q[$];
  result_t           want;

  function automatic logic [PtrW-1:0] ring_next(logic [PtrW-1:0] ptr);
    int d;
    int n;
    d = depth_reg;
    if (d < 2) d = 2;
    if (d > DepthCap) d = DepthCap;
    n = int'(ptr) + 1;
    if (n >= d) n = 0;
    return PtrW'(n);
  endfunction

  function automatic result_t queue_pair_result(req_kind_e kind, logic [DwordW-1:0] dw0,
                                                logic [CqeW-1:0] cqe);
    result_t r;
    int lim;
    r.outcome = OC_REJECTED;
    r.dword0  = '0;
    r.slot    = '0;
    r.sq_db   = '0;
    r.cq_db   = '0;
    r.status  = '0;
    r.cqe     = '0;
    if (kind == REQ_SUBMIT) begin
      if (!busy) begin
        r.outcome = OC_SUBMITTED;
        r.dword0  = {cid_next, dw0[15:0]};
        cid_next  = cid_next + 1'b1;
        r.slot    = sq_tail;
        sq_tail   = ring_next(sq_tail);
        r.sq_db   = sq_tail;
        busy      = 1'b1;
        stale_cnt = '0;
      end
    end else if (busy) begin
      if (cqe[0] == phase_exp) begin
        cq_head = ring_next(cq_head);
        if (cq_head == '0) phase_exp = ~phase_exp;
        r.status  = cqe[15:1];
        r.outcome = (r.status != '0) ? OC_DONE_ERR : OC_DONE_OK;
        r.cq_db   = cq_head;
        r.cqe     = cqe;
        busy      = 1'b0;
        stale_cnt = '0;
      end else begin
        lim = (limit_reg == '0) ? 1 : int'(limit_reg);
        stale_cnt = stale_cnt + 1'b1;
        if (int'(stale_cnt) >= lim) begin
          r.outcome = OC_TIMEOUT;
          busy      = 1'b0;
          stale_cnt = '0;
        end else begin
          r.outcome = OC_WAITING;
        end
      end
    end
    return r;
  endfunction

  function automatic int field_bad(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_reg  = DepthReset;
      limit_reg  = LimitReset;
      cid_next   = '0;
      sq_tail    = '0;
      cq_head    = '0;
      phase_exp  = 1'b1;
      busy       = 1'b0;
      stale_cnt  = '0;
      due_q.delete();
      fail_o     = 0;
      requests_o = 0;
      results_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgQueueDepth: depth_reg = cfg_data_i[DepthW-1:0];
          CfgPollLimit:  limit_reg = cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_o++;
        if (due_q.size() == 0) begin
          $error("result item arrived with no request waiting for it");
          fail_o++;
        end else begin
          want = due_q.pop_front();
          fail_o += field_bad("outcome", 32'(want.outcome), 32'(m_axis_tuser));
          fail_o += field_bad("cmd_dword0_out", want.dword0, m_axis_tdata[31:0]);
          fail_o += field_bad("sq_slot", 32'(want.slot), 32'(m_axis_tdata[37:32]));
          fail_o += field_bad("sq_doorbell_value", 32'(want.sq_db), 32'(m_axis_tdata[43:38]));
          fail_o += field_bad("cq_doorbell_value", 32'(want.cq_db), 32'(m_axis_tdata[49:44]));
          fail_o += field_bad("status_code", 32'(want.status), 32'(m_axis_tdata[64:50]));
          fail_o += field_bad("completion_status", 32'(want.cqe), 32'(m_axis_tdata[80:65]));
          fail_o += field_bad("zero fill", 32'd0, 32'(m_axis_tdata[87:81]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        requests_o++;
        due_q.push_back(queue_pair_result(req_kind_e'(s_axis_tuser), s_axis_tdata[31:0],
                                          s_axis_tdata[47:32]));
      end
    end
    pending_o = due_q.size();
    phase_o   = phase_exp;
  end

endmodule

// File: bench/testbench.sv
// Top of the NVMe queue pair engine bench: clock, reset, request stimulus,
// result back-pressure, register writes and the verdict.
// Depends on nqp_pkg, nvme_queue_pair_engine and nqp_checker.
`timescale 1ns / 1ps

module testbench;
  import nqp_pkg::*;

  localparam int StallLimit    = 2000;
  localparam int BurstCommands = 50;
  localparam int PhaseRaw      = 0;
  localparam int PhaseMatch    = 1;
  localparam int PhaseStale    = 2;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [OutcomeW-1:0]  m_axis_tuser;

  logic quiet;
  logic expect_phase;
  int   fails;
  int   pending;
  int   requests;
  int   results;
  int   sent;
  int   stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  nvme_queue_pair_engine #(
    .MAX_DEPTH(64)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  nqp_checker #(
    .MAX_DEPTH(64)
  ) result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_o        (fails),
    .pending_o     (pending),
    .requests_o    (requests),
    .results_o     (results),
    .phase_o       (expect_phase)
  );

  always @(negedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("nvme_queue_pair_engine regression: fail");
      $finish;
    end
  end

  task automatic send_item(input req_kind_e kind, input logic [DwordW-1:0] dw0,
                           input logic [CqeW-1:0] cqe, input int phase_mode);
    logic [CqeW-1:0] word;
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    word = cqe;
    if (phase_mode == PhaseMatch) word[0] = expect_phase;
    else if (phase_mode == PhaseStale) word[0] = ~expect_phase;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {word, dw0};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // A submit, zero to four stale polls, then the completion with the expected phase.
  task automatic run_command();
    int stale_n;
    send_item(REQ_SUBMIT, $urandom, CqeW'($urandom), PhaseRaw);
    stale_n = $urandom_range(0, 4);
    repeat (stale_n) send_item(REQ_POLL, $urandom, CqeW'($urandom), PhaseStale);
    send_item(REQ_POLL, $urandom, $urandom_range(0, 1) ? '0 : CqeW'($urandom), PhaseMatch);
  endtask

  task automatic random_run(input int count);
    int stop;
    stop = sent + count;
    while (sent < stop) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item($urandom_range(0, 1) ? REQ_POLL : REQ_SUBMIT, $urandom, CqeW'($urandom),
                  PhaseRaw);
      end else begin
        run_command();
      end
    end
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgQueueDepth;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_SUBMIT;
    m_axis_tready = 1'b0;
    quiet         = 1'b0;
    sent          = 0;
    stall_cycles  = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(REQ_POLL, 32'hFFFF_FFFF, 16'hFFFF, PhaseRaw);
    send_item(REQ_SUBMIT, 32'hFFFF_FFFF, 16'hFFFF, PhaseRaw);
    send_item(REQ_SUBMIT, 32'h0000_0000, 16'h0000, PhaseRaw);
    send_item(REQ_POLL, 32'h0, 16'hFFFF, PhaseStale);
    send_item(REQ_POLL, 32'h0, 16'hFFFF, PhaseMatch);
    send_item(REQ_SUBMIT, 32'h0000_0000, 16'h0000, PhaseRaw);
    send_item(REQ_POLL, 32'h0, 16'h0000, PhaseMatch);
    drain();

    // Shrink the rings below both pointers so they wrap on their next advance.
    write_reg(CfgQueueDepth, 23'd2);
    write_reg(CfgPollLimit, 23'd1);
    send_item(REQ_SUBMIT, 32'hA5A5_5A5A, 16'h0, PhaseRaw);
    send_item(REQ_POLL, 32'h0, 16'h1234, PhaseStale);
    send_item(REQ_POLL, 32'h0, 16'h0, PhaseMatch);
    send_item(REQ_SUBMIT, 32'h1234_ABCD, 16'h0, PhaseRaw);
    send_item(REQ_POLL, 32'h0, 16'h0, PhaseMatch);
    send_item(REQ_SUBMIT, 32'h5A5A_A5A5, 16'h0, PhaseRaw);
    send_item(REQ_POLL, 32'h0, 16'h0002, PhaseMatch);
    drain();

    write_reg(CfgQueueDepth, 23'd0);
    write_reg(CfgPollLimit, 23'd0);
    send_item(REQ_SUBMIT, $urandom, 16'h0, PhaseRaw);
    send_item(REQ_POLL, 32'h0, 16'h0, PhaseStale);
    drain();

    write_reg(CfgQueueDepth, 23'd1);
    write_reg(CfgPollLimit, 23'd3);
    send_item(REQ_SUBMIT, $urandom, 16'h0, PhaseRaw);
    repeat (3) send_item(REQ_POLL, 32'h0, 16'h8000, PhaseStale);
    drain();

    write_reg(CfgQueueDepth, 23'd127);
    write_reg(CfgPollLimit, 23'd5000000);
    send_item(REQ_SUBMIT, $urandom, 16'h0, PhaseRaw);
    send_item(REQ_POLL, 32'h0, 16'h0, PhaseMatch);
    drain();

    // Back-to-back commands with no gaps on either side.
    write_reg(CfgQueueDepth, 23'd64);
    write_reg(CfgPollLimit, 23'd1);
    quiet = 1'b1;
    repeat (BurstCommands) begin
      send_item(REQ_SUBMIT, $urandom, CqeW'($urandom), PhaseRaw);
      send_item(REQ_POLL, $urandom, CqeW'($urandom), PhaseRaw);
    end
    quiet = 1'b0;
    drain();

    sent = 0;
    write_reg(CfgPollLimit, 23'd5000000);
    random_run(120);
    write_reg(CfgQueueDepth, 23'd3);
    write_reg(CfgPollLimit, 23'd2);
    random_run(120);
    write_reg(CfgQueueDepth, {16'($urandom), 7'($urandom_range(2, 64))});
    write_reg(CfgPollLimit, 23'($urandom_range(1, 5)));
    random_run(120);
    write_reg(CfgQueueDepth, 23'h7F_FFFF);
    write_reg(CfgPollLimit, 23'h7F_FFFF);
    random_run(120);
    write_reg(CfgQueueDepth, 23'd2);
    write_reg(CfgPollLimit, 23'd0);
    random_run(120);
    repeat (5) @(posedge clk_i);

    $display("Checked %0d requests and %0d results over depths 2 to 64 and poll limits",
             requests, results);
    $display("from 0 to the maximum, with a gap-free burst, ring wraps and random stalls.");
    if (fails == 0 && pending == 0) begin
      $display("nvme_queue_pair_engine regression: pass");
    end else begin
      $display("nvme_queue_pair_engine regression: fail");
    end
    $finish;
  end

endmodule
